[design/rmv_pkg.sv]
// Package for the response majority voter: shared types and constants.
// No dependencies.
package rmv_pkg;
	localparam int RESP_W = 128;
	localparam int HALF_W = 64;
	localparam int CNT_W = 5;

	typedef struct packed {
		logic clear;
		logic load;
		logic search;
		logic insert;
		logic bump;
		logic scan;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic found;
		logic search_done;
		logic scan_done;
	} dp_stat_t;
endpackage

[design/response_majority_voter.sv]
// Top level of the response majority voter.
// Depends on rmv_pkg, rmv_ctrl, rmv_datapath.
//   channel | signals                                  | dir
//   in      | in_valid/in_ready, action, response_hi/lo | in
//   out     | out_valid/out_ready, bit/mode votes, ...  | out
//   cfg     | cfg_we, cfg_wdata (vote_count)            | in
// A response is searched against up to 16 table entries and then updates the
// table; a timeout skips the search. The last slot adds a scan of the used
// table entries and a hand-off of the result.
// Reset clears counters and the run; a stalled result holds input off.
module response_majority_voter #(
	parameter int MAX_VOTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [63:0] response_hi,
	input  logic [63:0] response_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] bit_vote_hi,
	output logic [63:0] bit_vote_lo,
	output logic [63:0] mode_vote_hi,
	output logic [63:0] mode_vote_lo,
	output logic        status,
	output logic [4:0]  received,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);
	import rmv_pkg::*;

	localparam int VC_W = $clog2(MAX_VOTES + 1);

	logic [4:0]      vc_q;
	logic [VC_W-1:0] count;
	dp_cmd_t         cmd;
	dp_stat_t        stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vc_q <= 5'd1;
		else if (cfg_we)
			vc_q <= cfg_wdata;
	end

	always_comb begin
		if (vc_q == '0)
			count = VC_W'(1);
		else if (32'(vc_q) > MAX_VOTES)
			count = VC_W'(MAX_VOTES);
		else
			count = VC_W'(vc_q);
	end

	rmv_ctrl #(.VC_W(VC_W)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .out_valid(out_valid), .out_ready(out_ready),
		.count(count), .cmd(cmd), .stat(stat)
	);

	rmv_datapath #(.MAX_VOTES(MAX_VOTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .action(action),
		.response_hi(response_hi), .response_lo(response_lo), .count(count),
		.bit_vote_hi(bit_vote_hi), .bit_vote_lo(bit_vote_lo),
		.mode_vote_hi(mode_vote_hi), .mode_vote_lo(mode_vote_lo),
		.status(status), .received(received)
	);
endmodule

[design/rmv_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module rmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

[design/rmv_datapath.sv]
// Datapath of the voter: ones counters, distinct-value table, search and scan.
// Depends on rmv_pkg and rmv_ram.
module rmv_datapath #(
	parameter int MAX_VOTES = 16,
	parameter int IDX_W = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1,
	parameter int VC_W = $clog2(MAX_VOTES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmv_pkg::dp_cmd_t       cmd,
	output rmv_pkg::dp_stat_t      stat,
	input  logic                   action,
	input  logic [63:0]            response_hi,
	input  logic [63:0]            response_lo,
	input  logic [VC_W-1:0]        count,
	output logic [63:0]            bit_vote_hi,
	output logic [63:0]            bit_vote_lo,
	output logic [63:0]            mode_vote_hi,
	output logic [63:0]            mode_vote_lo,
	output logic                   status,
	output logic [4:0]             received
);
	import rmv_pkg::*;

	logic [VC_W-1:0]   ones_q [RESP_W];
	logic [RESP_W-1:0] resp_q;
	logic [VC_W:0]     used_q;
	logic [VC_W:0]     idx_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [VC_W:0]     best_q;
	logic [RESP_W-1:0] mode_q;
	logic [VC_W:0]     recv_q;
	logic              found_q;
	logic [IDX_W-1:0]  hit_q;

	logic [RESP_W-1:0] val_rd;
	logic [VC_W-1:0]   cnt_rd;
	logic              val_we, cnt_we;
	logic              room;
	logic [IDX_W-1:0]  addr;
	logic [VC_W-1:0]   cnt_wd;
	logic [VC_W:0]     c_ext;
	logic [RESP_W-1:0] resp_in;
	logic [RESP_W-1:0] vote_bits;

	assign resp_in = {response_hi, response_lo};
	assign room = used_q < (VC_W+1)'(MAX_VOTES);
	assign val_we = cmd.insert && room;
	assign cnt_we = (cmd.insert && room) || cmd.bump;
	assign cnt_wd = cmd.insert ? VC_W'(1) : VC_W'(cnt_rd + 1'b1);
	always_comb begin
		if (cmd.insert)
			addr = used_q[IDX_W-1:0];
		else if (cmd.bump || (cmd.search && found_q))
			addr = hit_q;
		else
			addr = idx_q[IDX_W-1:0];
	end

	rmv_ram #(.WIDTH(RESP_W), .DEPTH(MAX_VOTES)) u_val (
		.clk(clk), .we(val_we), .addr(addr), .wdata(resp_q), .rdata(val_rd)
	);
	rmv_ram #(.WIDTH(VC_W), .DEPTH(MAX_VOTES)) u_cnt (
		.clk(clk), .we(cnt_we), .addr(addr), .wdata(cnt_wd), .rdata(cnt_rd)
	);

	assign c_ext = {1'b0, cnt_rd};
	assign stat.found = found_q;
	assign stat.search_done = !rd_vld_q && (found_q || idx_q >= used_q);
	assign stat.scan_done = !rd_vld_q && idx_q >= used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q <= '0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
			found_q <= 1'b0;
			hit_q <= '0;
			for (int i = 0; i < RESP_W; i++)
				ones_q[i] <= '0;
		end else begin
			rd_vld_q <= 1'b0;
			if (cmd.clear) begin
				used_q <= '0;
				for (int i = 0; i < RESP_W; i++)
					ones_q[i] <= '0;
			end
			if (cmd.load) begin
				idx_q <= '0;
				found_q <= 1'b0;
				if (!action)
					for (int i = 0; i < RESP_W; i++)
						ones_q[i] <= ones_q[i] + VC_W'(resp_in[i]);
			end
			if ((cmd.search || cmd.scan) && !rd_vld_q && idx_q < used_q
					&& !(cmd.search && found_q)) begin
				rd_vld_q <= 1'b1;
				rd_idx_q <= idx_q[IDX_W-1:0];
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.search && rd_vld_q && val_rd == resp_q) begin
				found_q <= 1'b1;
				hit_q <= rd_idx_q;
			end
			if (cmd.insert && room)
				used_q <= used_q + 1'b1;
			if (cmd.finish)
				idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			resp_q <= resp_in;
		if (cmd.finish) begin
			best_q <= '0;
			mode_q <= '0;
			recv_q <= '0;
		end
		if (cmd.scan && rd_vld_q) begin
			recv_q <= recv_q + c_ext;
			if (c_ext > best_q || (c_ext == best_q && c_ext != '0 && val_rd < mode_q)) begin
				best_q <= c_ext;
				mode_q <= val_rd;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < RESP_W; i++)
			vote_bits[i] = ({ones_q[i], 1'b0} >= {1'b0, count});
	end
	assign {bit_vote_hi, bit_vote_lo} = vote_bits;
	assign {mode_vote_hi, mode_vote_lo} = mode_q;
	assign received = 5'(recv_q);
	assign status = (count == VC_W'(1)) && (recv_q == '0);

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (VC_W+1)'(MAX_VOTES)) else $error("table overfilled");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.insert && cmd.bump)) else $error("insert and bump together");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> used_q == '0) else $error("clear failed");
`endif
endmodule

[design/rmv_ctrl.sv]
// Controller of the voter: sequences load, search, update, scan and output.
// Depends on rmv_pkg.
module rmv_ctrl #(
	parameter int VC_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic [VC_W-1:0]    count,
	output rmv_pkg::dp_cmd_t   cmd,
	input  rmv_pkg::dp_stat_t  stat
);
	import rmv_pkg::*;

	typedef enum logic [2:0] {IDLE, SEARCH, UPDATE, SCAN, DONE} state_t;
	state_t state_q;
	logic   act_q;
	logic [VC_W-1:0] seen_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.search = (state_q == SEARCH);
		cmd.insert = (state_q == UPDATE) && !act_q && !stat.found;
		cmd.bump = (state_q == UPDATE) && !act_q && stat.found;
		cmd.scan = (state_q == SCAN);
		cmd.finish = (state_q == UPDATE) && (seen_q >= count);
		cmd.clear = (state_q == DONE) && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			act_q <= 1'b0;
			seen_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					act_q <= action;
					seen_q <= seen_q + 1'b1;
					state_q <= action ? UPDATE : SEARCH;
				end
				SEARCH: if (stat.search_done)
					state_q <= UPDATE;
				UPDATE: begin
					if (seen_q >= count)
						state_q <= SCAN;
					else
						state_q <= IDLE;
				end
				SCAN: if (stat.scan_done) begin
					out_valid <= 1'b1;
					state_q <= DONE;
				end
				DONE: if (out_ready) begin
					out_valid <= 1'b0;
					seen_q <= '0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == DONE) else $error("result outside done");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DONE |-> out_valid) else $error("done without result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
`endif
endmodule
